/* sv/arq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_pkg
// shared constants, types and helpers of the active/expired run queue
// ----------------------------------------------------------------------------
package arq_pkg;

  localparam int MAX_LEVELS   = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int MAX_PROCS    = 256;
  localparam int LEVELS_RESET = 4;

  localparam int NUM_FIFOS = 2 * MAX_LEVELS;
  localparam int Q_W       = $clog2(NUM_FIFOS);
  localparam int LVL_W     = $clog2(MAX_LEVELS);
  localparam int NL_W      = $clog2(MAX_LEVELS + 1);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int META_W    = PTR_W + CNT_W;
  localparam int ID_W      = $clog2(MAX_PROCS);
  localparam int ENT_DEPTH = NUM_FIFOS * QUEUE_DEPTH;
  localparam int ENT_AW    = $clog2(ENT_DEPTH);

  // fixed field widths
  localparam int PID_W = 8;
  localparam int PRI_W = 4;
  localparam int SL_W  = 3;
  localparam int ST_W  = 2;
  localparam int CFG_W = 4;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // raw code of the expired dynamic priority (-1)
  localparam logic [PRI_W-1:0] PRI_EXPIRED = 4'hF;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_META = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  // target selection for one request
  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [LVL_W-1:0] level;
    logic             enq_ok;
    logic             expired;
    logic             deq_got;
    logic             swap;
  } pick_t;

  function automatic logic [Q_W-1:0] fifo_idx(input logic bank, input logic [LVL_W-1:0] lvl);
    fifo_idx = (bank ? Q_W'(MAX_LEVELS) : Q_W'(0)) + Q_W'(lvl);
  endfunction

endpackage

/* sv/arq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq channel interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface arq_in_if import arq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [PID_W-1:0]        proc_id;
  logic signed [PRI_W-1:0] dynamic_priority;
  logic [PRI_W-1:0]        static_priority;

  modport source (output valid, mode, proc_id, dynamic_priority, static_priority,
                  input ready);
  modport sink   (input valid, mode, proc_id, dynamic_priority, static_priority,
                  output ready);
endinterface

interface arq_out_if import arq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PID_W-1:0] served_id;
  logic [SL_W-1:0]  served_level;
  logic             to_expired;
  logic [ST_W-1:0]  status;
  logic             all_empty;

  modport source (output valid, served_id, served_level, to_expired, status, all_empty,
                  input ready);
  modport sink   (input valid, served_id, served_level, to_expired, status, all_empty,
                  output ready);
endinterface

interface arq_cfg_if import arq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] levels_in_use;

  modport source (output valid, levels_in_use, input ready);
  modport sink   (input valid, levels_in_use, output ready);
endinterface

/* sv/arq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module arq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/arq_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_pick
// picks the fifo a request works on from the non-empty flags
// ----------------------------------------------------------------------------
module arq_pick import arq_pkg::*; (
  input  logic [NUM_FIFOS-1:0]  nonempty,
  input  logic [MAX_LEVELS-1:0] use_mask,
  input  logic [NL_W-1:0]       n_used,
  input  logic                  active_bank,
  input  logic                  mode,
  input  logic [PRI_W-1:0]      dyn_pri,
  input  logic [PRI_W-1:0]      stat_pri,
  output pick_t                 pick
);

  logic [MAX_LEVELS-1:0] act_hit;
  logic [MAX_LEVELS-1:0] oth_hit;
  logic [LVL_W-1:0]      act_lvl;
  logic [LVL_W-1:0]      oth_lvl;
  logic                  deq_bank;
  logic [LVL_W-1:0]      deq_lvl;
  logic                  enq_bank;
  logic [LVL_W-1:0]      enq_lvl;

  // highest non-empty level in use of each bank
  always_comb begin
    act_lvl = '0;
    oth_lvl = '0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      act_hit[l] = nonempty[fifo_idx(active_bank, LVL_W'(l))] & use_mask[l];
      oth_hit[l] = nonempty[fifo_idx(~active_bank, LVL_W'(l))] & use_mask[l];
      if (act_hit[l]) act_lvl = LVL_W'(l);
      if (oth_hit[l]) oth_lvl = LVL_W'(l);
    end
  end

  always_comb begin
    // dequeue side
    pick.swap    = ~|act_hit;
    pick.deq_got = (|act_hit) | (|oth_hit);
    deq_bank     = pick.swap ? ~active_bank : active_bank;
    deq_lvl      = pick.swap ? oth_lvl : act_lvl;

    // enqueue side
    pick.expired = 1'b0;
    pick.enq_ok  = 1'b0;
    enq_bank     = active_bank;
    enq_lvl      = '0;
    if (!dyn_pri[PRI_W-1]) begin
      pick.enq_ok = {1'b0, dyn_pri[PRI_W-2:0]} < PRI_W'(n_used);
      enq_lvl     = LVL_W'(dyn_pri[PRI_W-2:0]);
    end else if (dyn_pri == PRI_EXPIRED) begin
      pick.expired = 1'b1;
      enq_bank     = ~active_bank;
      pick.enq_ok  = (stat_pri != '0) && (stat_pri <= PRI_W'(n_used));
      enq_lvl      = LVL_W'(stat_pri - PRI_W'(1));
    end

    if (mode == MODE_DEQ) begin
      pick.q     = fifo_idx(deq_bank, deq_lvl);
      pick.level = deq_lvl;
    end else begin
      pick.q     = fifo_idx(enq_bank, enq_lvl);
      pick.level = enq_lvl;
    end
  end

endmodule

/* sv/active_expired_priority_run_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// active_expired_priority_run_queue
// two-bank multilevel run queue with per-level fifos held in ram
// ----------------------------------------------------------------------------
// Each request (enqueue or dequeue) gives one result and passes from
// acceptance to a result in the output register in order: the fifo pointer
// ram is read in the accept cycle (S_IDLE), the pointers are updated and the
// entry ram is written or read in S_META, and the result is loaded in S_OUT
// once the output register is free. The two dependent ram reads of a dequeue
// (pointers, then the id) set this sequence; the next request is taken once
// the result is loaded, even while it still waits on the output. Per-fifo
// valid bits make the pointer ram read as zero after reset, so there is no
// clearing pass; the entry ram is only read where the count says an entry is valid.
// ----------------------------------------------------------------------------
module active_expired_priority_run_queue import arq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  arq_in_if.sink     in_ch,
  arq_out_if.source  out_ch,
  arq_cfg_if.sink    cfg_ch
);

  state_t               state_r, state_nxt;
  logic                 active_bank_r;
  logic [CFG_W-1:0]     levels_r;
  logic [NUM_FIFOS-1:0] nonempty_r;   // fifo holds at least one id
  logic [NUM_FIFOS-1:0] meta_vld_r;   // pointer ram entry has been written

  // latched request
  logic                 req_mode_r;
  logic [PID_W-1:0]     req_pid_r;
  pick_t                pick_r;

  // result waiting for the output register
  status_t              res_status_r;
  logic [SL_W-1:0]      res_level_r;
  logic                 res_toexp_r;
  logic                 res_deq_r;

  // output register
  logic                 out_valid_r;
  logic [PID_W-1:0]     out_id_r;
  logic [SL_W-1:0]      out_level_r;
  logic                 out_toexp_r;
  status_t              out_status_r;
  logic                 out_empty_r;

  logic [NL_W-1:0]       n_used;
  logic [MAX_LEVELS-1:0] use_mask;
  pick_t                 pick;
  logic                  in_acc;
  logic                  out_load;

  // pointer ram
  logic [META_W-1:0] meta_rdata;
  logic [META_W-1:0] meta_wdata;
  logic              meta_we;
  logic [PTR_W-1:0]  m_head;
  logic [CNT_W-1:0]  m_count;
  logic [CNT_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_next;

  // entry ram
  logic              ent_we;
  logic              ent_re;
  logic [ENT_AW-1:0] ent_addr;
  logic [ID_W-1:0]   ent_rdata;

  // config register: always ready; the user writes it only while idle, the block does not enforce this
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= CFG_W'(LEVELS_RESET);
    end else if (cfg_ch.valid) begin
      levels_r <= cfg_ch.levels_in_use;
    end
  end

  // levels in use, zero acts as one, clamp at the bank size
  always_comb begin
    if (levels_r == '0) begin
      n_used = NL_W'(1);
    end else if (levels_r > CFG_W'(MAX_LEVELS)) begin
      n_used = NL_W'(MAX_LEVELS);
    end else begin
      n_used = NL_W'(levels_r);
    end
    for (int l = 0; l < MAX_LEVELS; l++) begin
      use_mask[l] = NL_W'(l) < n_used;
    end
  end

  arq_pick u_pick (
    .nonempty    (nonempty_r),
    .use_mask    (use_mask),
    .n_used      (n_used),
    .active_bank (active_bank_r),
    .mode        (in_ch.mode),
    .dyn_pri     (in_ch.dynamic_priority),
    .stat_pri    (in_ch.static_priority),
    .pick        (pick)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // pointer fields, an unwritten entry reads as empty
  assign m_head  = meta_vld_r[pick_r.q] ? meta_rdata[META_W-1:CNT_W] : '0;
  assign m_count = meta_vld_r[pick_r.q] ? meta_rdata[CNT_W-1:0] : '0;

  // tail and next head wrap around the fifo depth
  assign tail_sum  = (CNT_W+1)'(m_head) + (CNT_W+1)'(m_count);
  assign tail      = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                   ? PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_next = (m_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : m_head + PTR_W'(1);

  // read-modify-write of the pointers in S_META
  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = {m_head, m_count};
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_addr   = ENT_AW'(pick_r.q) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(tail);
    if (state_r == S_META) begin
      if (req_mode_r == MODE_ENQ) begin
        if (pick_r.enq_ok && (m_count < CNT_W'(QUEUE_DEPTH))) begin
          meta_we    = 1'b1;
          meta_wdata = {m_head, m_count + CNT_W'(1)};
          ent_we     = 1'b1;
        end
      end else if (pick_r.deq_got) begin
        meta_we    = 1'b1;
        meta_wdata = {head_next, m_count - CNT_W'(1)};
        ent_re     = 1'b1;
        ent_addr   = ENT_AW'(pick_r.q) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(m_head);
      end
    end
  end

  arq_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_FIFOS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (pick_r.q),
    .wdata (meta_wdata),
    .re    (in_acc),
    .raddr (pick.q),
    .rdata (meta_rdata)
  );

  arq_ram #(
    .WIDTH (ID_W),
    .DEPTH (ENT_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_addr),
    .wdata (ID_W'(req_pid_r)),
    .re    (ent_re),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_META;
      S_META:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_bank_r <= 1'b0;
      nonempty_r    <= '0;
      meta_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      // a dequeue that finds the active bank empty swaps the banks
      if (in_acc && (in_ch.mode == MODE_DEQ) && pick.swap) begin
        active_bank_r <= ~active_bank_r;
      end
      if (meta_we) begin
        meta_vld_r[pick_r.q] <= 1'b1;
        nonempty_r[pick_r.q] <= (meta_wdata[CNT_W-1:0] != '0);
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode_r <= in_ch.mode;
      req_pid_r  <= in_ch.proc_id;
      pick_r     <= pick;
    end
  end

  // result fields decided in the pointer cycle
  always_ff @(posedge clk) begin
    if (state_r == S_META) begin
      if (req_mode_r == MODE_ENQ) begin
        res_deq_r <= 1'b0;
        if (!pick_r.enq_ok) begin
          res_status_r <= ST_RANGE;
          res_level_r  <= '0;
          res_toexp_r  <= 1'b0;
        end else if (m_count >= CNT_W'(QUEUE_DEPTH)) begin
          res_status_r <= ST_FULL;
          res_level_r  <= SL_W'(pick_r.level);
          res_toexp_r  <= 1'b0;
        end else begin
          res_status_r <= ST_OK;
          res_level_r  <= SL_W'(pick_r.level);
          res_toexp_r  <= pick_r.expired;
        end
      end else if (pick_r.deq_got) begin
        res_status_r <= ST_OK;
        res_level_r  <= SL_W'(pick_r.level);
        res_toexp_r  <= 1'b0;
        res_deq_r    <= 1'b1;
      end else begin
        res_status_r <= ST_EMPTY;
        res_level_r  <= '0;
        res_toexp_r  <= 1'b0;
        res_deq_r    <= 1'b0;
      end
    end
  end

  // output register, the popped id comes straight from the entry ram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r     <= res_deq_r ? PID_W'(ent_rdata) : '0;
      out_level_r  <= res_level_r;
      out_toexp_r  <= res_toexp_r;
      out_status_r <= res_status_r;
      out_empty_r  <= ~|(nonempty_r & {use_mask, use_mask});
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.served_id    = out_id_r;
  assign out_ch.served_level = out_level_r;
  assign out_ch.to_expired   = out_toexp_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.all_empty    = out_empty_r;

endmodule

/* tb/active_expired_priority_run_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// active_expired_priority_run_queue_tb
// self-checking bench for the two-bank multilevel run queue
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. Its easy rows carry a typed
// result and the rest use the software run queue kept in this bench. After the
// table, random phases follow. Each phase first writes a new level count while
// the block is idle, including 0, 1, 8 and 15. It then sends a mix of mostly
// well-formed requests and some noise. Both sides idle in random bursts, and
// the sink holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module active_expired_priority_run_queue_tb;
  import arq_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int NUM_PHASES      = 13;
  localparam int REQS_PER_PHASE  = 92;
  localparam int SINK_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_DIR_ROWS    = 18;
  localparam int PEND_DEPTH      = 8;

  // level register value for each random phase, extremes included
  localparam logic [CFG_W-1:0] PHASE_LEVELS [NUM_PHASES] =
    '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd6, 4'd1, 4'd5, 4'd7, 4'd4, 4'd8};

  // one result of the run queue
  typedef struct packed {
    logic [PID_W-1:0] served_id;
    logic [SL_W-1:0]  served_level;
    logic             to_expired;
    status_t          status;
    logic             all_empty;
  } run_result_t;

  // one directed request; has_typed marks a result typed into the row
  typedef struct packed {
    logic             mode;
    logic [PID_W-1:0] proc_id;
    logic [PRI_W-1:0] dyn_pri;
    logic [PRI_W-1:0] stat_pri;
    logic             has_typed;
    run_result_t      typed;
  } sched_row_t;

  localparam run_result_t NO_RESULT = '{8'h00, 3'd0, 1'b0, ST_OK, 1'b0};

  // directed table, levels in use at reset value (4)
  localparam sched_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // dequeue on an empty store: swaps banks, nothing to serve
    '{MODE_DEQ, 8'h00, 4'h0, 4'h0, 1'b1, '{8'h00, 3'd0, 1'b0, ST_EMPTY, 1'b1}},
    // active enqueues at lowest and highest level in use, id extremes
    '{MODE_ENQ, 8'hFF, 4'h0, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b0, ST_OK, 1'b0}},
    '{MODE_ENQ, 8'h00, 4'h3, 4'h8, 1'b1, '{8'h00, 3'd3, 1'b0, ST_OK, 1'b0}},
    // dynamic priority at or above levels in use, and negatives other than -1
    '{MODE_ENQ, 8'h12, 4'h4, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    '{MODE_ENQ, 8'h34, 4'h7, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    '{MODE_ENQ, 8'h56, 4'hE, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    '{MODE_ENQ, 8'h78, 4'h8, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    // expired with static priority zero or past the levels in use
    '{MODE_ENQ, 8'h9A, 4'hF, 4'h0, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    '{MODE_ENQ, 8'hBC, 4'hF, 4'h5, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    // expired enqueues into the other bank
    '{MODE_ENQ, 8'hA5, 4'hF, 4'h1, 1'b1, '{8'h00, 3'd0, 1'b1, ST_OK, 1'b0}},
    '{MODE_ENQ, 8'h5A, 4'hF, 4'h4, 1'b1, '{8'h00, 3'd3, 1'b1, ST_OK, 1'b0}},
    '{MODE_ENQ, 8'hDE, 4'hF, 4'hF, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b0}},
    // drain: active levels high to low, then swap into the expired bank
    '{MODE_DEQ, 8'h00, 4'h0, 4'h0, 1'b0, NO_RESULT},
    '{MODE_DEQ, 8'h00, 4'h0, 4'h0, 1'b0, NO_RESULT},
    '{MODE_DEQ, 8'h00, 4'h0, 4'h0, 1'b0, NO_RESULT},
    '{MODE_DEQ, 8'h00, 4'h0, 4'h0, 1'b0, NO_RESULT},
    // empty again, other fields ignored by a dequeue
    '{MODE_DEQ, 8'hFF, 4'hF, 4'hF, 1'b1, '{8'h00, 3'd0, 1'b0, ST_EMPTY, 1'b1}},
    '{MODE_ENQ, 8'h3C, 4'hF, 4'h8, 1'b1, '{8'h00, 3'd0, 1'b0, ST_RANGE, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  arq_in_if  in_ch ();
  arq_out_if out_ch ();
  arq_cfg_if cfg_ch ();

  active_expired_priority_run_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // software copy of the run queue
  logic [PID_W-1:0] run_ids  [NUM_FIFOS][QUEUE_DEPTH];
  int               run_head [NUM_FIFOS];
  int               run_fill [NUM_FIFOS];
  logic             run_bank;
  logic [CFG_W-1:0] run_levels;

  // expected results in request order, ring buffer
  run_result_t expected_runs [PEND_DEPTH];
  int          pend_wr        = 0;
  int          pend_rd        = 0;
  int          pend_count     = 0;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;

  // typed result for the request on the bus, moves with the payload
  logic        row_has_typed;
  run_result_t row_typed;

  // idling controls shared by the request and result sides
  logic tx_gaps_on;
  logic rx_gaps_on;
  logic sink_hold_req;

  // register value to levels actually in use
  function automatic int levels_active(input logic [CFG_W-1:0] lv);
    if (lv == '0) return 1;
    if (int'(lv) > MAX_LEVELS) return MAX_LEVELS;
    return int'(lv);
  endfunction

  // applies one request to the software run queue and returns its result
  function automatic run_result_t predict_run(input logic mode,
                                              input logic [PID_W-1:0] pid,
                                              input logic [PRI_W-1:0] dyn_pri,
                                              input logic [PRI_W-1:0] stat_pri);
    run_result_t r;
    int   n, lvl, fifo, slot, b, pass;
    logic bank, ok, expired, found;
    r     = NO_RESULT;
    n     = levels_active(run_levels);
    found = 1'b0;
    if (mode == MODE_ENQ) begin
      ok      = 1'b1;
      expired = 1'b0;
      bank    = run_bank;
      lvl     = 0;
      if (dyn_pri < 4'd8) begin
        lvl = int'(dyn_pri);
        ok  = (lvl < n);
      end else if (dyn_pri == PRI_EXPIRED) begin
        // expired: other bank, one below the static priority
        expired = 1'b1;
        bank    = ~run_bank;
        lvl     = int'(stat_pri) - 1;
        ok      = (stat_pri != '0) && (lvl < n);
      end else begin
        ok = 1'b0;
      end
      if (!ok) begin
        r.status = ST_RANGE;
      end else begin
        fifo           = int'(bank) * MAX_LEVELS + lvl;
        r.served_level = SL_W'(lvl);
        if (run_fill[fifo] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot                = (run_head[fifo] + run_fill[fifo]) % QUEUE_DEPTH;
          run_ids[fifo][slot] = pid;
          run_fill[fifo]++;
          r.to_expired        = expired;
        end
      end
    end else begin
      // highest active level first; swap banks once if the active bank is dry
      for (pass = 0; pass < 2 && !found; pass++) begin
        if (pass == 1) run_bank = ~run_bank;
        for (lvl = n - 1; lvl >= 0 && !found; lvl--) begin
          fifo = int'(run_bank) * MAX_LEVELS + lvl;
          if (run_fill[fifo] != 0) begin
            found          = 1'b1;
            r.served_id    = run_ids[fifo][run_head[fifo]];
            r.served_level = SL_W'(lvl);
            run_head[fifo] = (run_head[fifo] + 1) % QUEUE_DEPTH;
            run_fill[fifo]--;
          end
        end
      end
      if (!found) r.status = ST_EMPTY;
    end
    // levels beyond the ones in use do not count
    r.all_empty = 1'b1;
    for (b = 0; b < 2; b++)
      for (lvl = 0; lvl < n; lvl++)
        if (run_fill[b * MAX_LEVELS + lvl] != 0) r.all_empty = 1'b0;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // sends one request and returns once it is accepted; valid stays high
  task automatic offer_request(input logic mode, input logic [PID_W-1:0] pid,
                               input logic [PRI_W-1:0] dyn_pri,
                               input logic [PRI_W-1:0] stat_pri,
                               input logic has_typed, input run_result_t typed);
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= mode;
    in_ch.proc_id          <= pid;
    in_ch.dynamic_priority <= dyn_pri;
    in_ch.static_priority  <= stat_pri;
    row_has_typed          <= has_typed;
    row_typed              <= typed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // request side: reset, directed table, then random phases
  initial begin : stimulus
    int          ph, k, n, roll;
    logic        mode;
    logic [PID_W-1:0] pid;
    logic [PRI_W-1:0] dyn_pri, stat_pri;
    int          enq_pct;

    // every block input known from time zero
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = MODE_ENQ;
    in_ch.proc_id          = '0;
    in_ch.dynamic_priority = '0;
    in_ch.static_priority  = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.levels_in_use   = CFG_W'(LEVELS_RESET);
    row_has_typed          = 1'b0;
    row_typed              = NO_RESULT;
    tx_gaps_on             = 1'b0;
    rx_gaps_on             = 1'b1;
    sink_hold_req          = 1'b0;

    // software queue reset state
    for (k = 0; k < NUM_FIFOS; k++) begin
      run_head[k] = 0;
      run_fill[k] = 0;
    end
    run_bank   = 1'b0;
    run_levels = CFG_W'(LEVELS_RESET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, back to back
    for (k = 0; k < NUM_DIR_ROWS; k++)
      offer_request(DIR_ROWS[k].mode, DIR_ROWS[k].proc_id, DIR_ROWS[k].dyn_pri,
                    DIR_ROWS[k].stat_pri, DIR_ROWS[k].has_typed, DIR_ROWS[k].typed);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // level count only changes while nothing is in flight
      in_ch.valid <= 1'b0;
      // let the monitor count the last accepted request first
      @(posedge clk);
      while (pend_count != 0) @(posedge clk);
      cfg_ch.valid         <= 1'b1;
      cfg_ch.levels_in_use <= PHASE_LEVELS[ph];
      do @(posedge clk); while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;

      n = levels_active(PHASE_LEVELS[ph]);
      // balanced, fill-heavy and drain-heavy phases in turn
      case (ph % 3)
        0: enq_pct = 60;
        1: enq_pct = 80;
        default: enq_pct = 40;
      endcase
      // no idling in the last two phases
      tx_gaps_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 2) != 0);
      rx_gaps_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 2) != 0);
      // long sink stall while requests keep coming
      if (ph == 1 || ph == 7) sink_hold_req = 1'b1;

      for (k = 0; k < REQS_PER_PHASE; k++) begin
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pid  = PID_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          // noise: any field pattern
          mode     = logic'($urandom_range(0, 1));
          dyn_pri  = PRI_W'($urandom_range(0, 15));
          stat_pri = PRI_W'($urandom_range(0, 15));
        end else begin
          // well-formed: valid level or expired with a valid static priority
          mode     = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
          stat_pri = PRI_W'($urandom_range(1, n));
          if ($urandom_range(0, 1) == 0) dyn_pri = PRI_EXPIRED;
          else dyn_pri = PRI_W'($urandom_range(0, n - 1));
        end
        offer_request(mode, pid, dyn_pri, stat_pri, 1'b0, NO_RESULT);
      end
    end

    // drain, then keep watching for DRAIN_CYCLES to catch stray results
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("active_expired_priority_run_queue test passed");
    end else begin
      $display("active_expired_priority_run_queue test failed");
    end
    $finish;
  end

  // result side: random stall bursts plus the long hold on request
  initial begin : result_sink
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // monitor: compare at result accept, predict at request accept
  always @(posedge clk) begin : monitor
    run_result_t want_run;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) run_levels = cfg_ch.levels_in_use;
      if (out_ch.valid && out_ch.ready) begin
        if (pend_count == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual id %0d level %0d status %0d",
                   $time, out_ch.served_id, out_ch.served_level, out_ch.status);
        end else begin
          want_run   = expected_runs[pend_rd];
          pend_rd    = (pend_rd + 1) % PEND_DEPTH;
          pend_count = pend_count - 1;
          check_field("served_id", want_run.served_id, out_ch.served_id);
          check_field("served_level", want_run.served_level, out_ch.served_level);
          check_field("to_expired", want_run.to_expired, out_ch.to_expired);
          check_field("status", want_run.status, out_ch.status);
          check_field("all_empty", want_run.all_empty, out_ch.all_empty);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want_run = predict_run(in_ch.mode, in_ch.proc_id, in_ch.dynamic_priority,
                               in_ch.static_priority);
        // typed rows replace the software result, state still advances
        if (row_has_typed) want_run = row_typed;
        expected_runs[pend_wr] = want_run;
        pend_wr                = (pend_wr + 1) % PEND_DEPTH;
        pend_count             = pend_count + 1;
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("active_expired_priority_run_queue test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
